@@ rtl/size_class_bank_allocator_defines.svh @@
// assertion macros shared by the allocator rtl
`ifndef SIZE_CLASS_BANK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BANK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, checked out of reset
`define SCBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/scba_pkg.sv @@
// package: constants, types and helpers of the size class allocator
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int BANK_SH     = 13;                 // log2 of bank bytes
  localparam int MAP_DEPTH   = 1024;
  localparam int ROW_W       = 32;
  localparam int ROWS        = MAP_DEPTH / ROW_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int BIT_AW      = $clog2(ROW_W);
  localparam int POS_W       = ROW_AW + BIT_AW;
  localparam int BASE_W      = 11;                 // five counts of up to 255
  localparam int SEG_W       = 14;
  localparam int CFG_W       = 40;
  localparam int DVD_W       = 8 + BANK_SH;

  localparam logic [2:0] CFG_COUNTS = 3'd5;
  localparam logic [2:0] CFG_FIRSTS = 3'd6;

  localparam logic [BASE_W-1:0] MAP_LIMIT = BASE_W'(MAP_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_RD, S_CHK, S_MUL, S_FORM, S_FSEL, S_FDIV, S_FIDX, S_FIN
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } map_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [SEG_W-1:0] divisor;
  } div_req_t;

  // bitmap position of the first segment of class c
  function automatic logic [BASE_W-1:0] base_of(input logic [CFG_W-1:0] counts,
                                                input logic [2:0] c);
    logic [BASE_W-1:0] b;
    b = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (3'(k) < c) b = b + BASE_W'(counts[8*k +: 8]);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/size_class_bank_allocator.sv @@
// top level: config registers, request sequencer and result register
// after reset the used-bit map is cleared row by row, in_stall stays high meanwhile
// allocate: S_CLASS tries each class, S_RD and S_CHK scan each bitmap row, then S_MUL and
//   S_FORM form the result; the sequencer walks 32-bit rows of the map through its single read port
// free: runs the 21-step divider, then one map read-modify-write
// one word in flight at a time; the result register lets the next word be taken
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_bank_allocator_defines.svh"
module size_class_bank_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [39:0] cfg_wdata,
  // request word
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [13:0] in_req_size,
  input  wire logic [7:0]  in_free_bank,
  input  wire logic [12:0] in_free_offset,
  // result word
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [7:0]       out_bank,
  output logic [12:0]      out_offset
);
  localparam int BW = scba_pkg::BASE_W;

  // configuration registers
  logic [scba_pkg::SEG_W-1:0] seg_size_r [scba_pkg::NUM_CLASSES];
  logic [scba_pkg::CFG_W-1:0] counts_r;
  logic [scba_pkg::CFG_W-1:0] firsts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_size_r[0] <= 14'd32;
      seg_size_r[1] <= 14'd64;
      seg_size_r[2] <= 14'd128;
      seg_size_r[3] <= 14'd256;
      seg_size_r[4] <= 14'd1024;
      counts_r      <= '0;
      firsts_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_index < 3'(scba_pkg::NUM_CLASSES))
        seg_size_r[cfg_index] <= cfg_wdata[scba_pkg::SEG_W-1:0];
      else if (cfg_index == scba_pkg::CFG_COUNTS) counts_r <= cfg_wdata;
      else if (cfg_index == scba_pkg::CFG_FIRSTS) firsts_r <= cfg_wdata;
    end
  end

  // sequencer state
  scba_pkg::state_t           state_r, state_nxt;
  logic                       type_r, type_nxt;
  logic [13:0]                size_r, size_nxt;
  logic [7:0]                 fbank_r, fbank_nxt;
  logic [12:0]                foff_r, foff_nxt;
  logic [2:0]                 cls_r, cls_nxt;
  logic [BW-1:0]              base_r, base_nxt;
  logic [BW-1:0]              end_r, end_nxt;
  logic [scba_pkg::ROW_AW-1:0] row_r, row_nxt;
  logic [scba_pkg::BIT_AW-1:0] bit_r, bit_nxt;
  logic [7:0]                 j_r, j_nxt;
  logic [21:0]                prod_r, prod_nxt;
  logic                       res_ok_r, res_ok_nxt;
  logic [7:0]                 res_bank_r, res_bank_nxt;
  logic [12:0]                res_off_r, res_off_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic                       ook_r, ook_nxt;
  logic [7:0]                 obank_r, obank_nxt;
  logic [12:0]                ooff_r, ooff_nxt;

  scba_pkg::map_req_t         map_req;
  scba_pkg::div_req_t         div_req;
  logic                       map_busy;
  logic [scba_pkg::ROW_W-1:0] row_data;
  logic                       div_done;
  logic [scba_pkg::DVD_W-1:0] quot;

  scba_map u_map (.clk(clk), .rst_n(rst_n), .req(map_req), .busy(map_busy),
                  .rd_data(row_data));
  scba_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quot(quot));

  // per-state helper values
  logic [scba_pkg::SEG_W-1:0] seg_cur;
  logic [7:0]                 cnt_cur;
  logic [7:0]                 first_cur;
  logic [BW-1:0]              cls_base;
  logic [BW-1:0]              cls_end;
  logic [scba_pkg::ROW_W-1:0] free_mask;
  logic                       hit;
  logic [scba_pkg::BIT_AW-1:0] hit_idx;
  logic [BW-1:0]              abs_pos;
  logic [BW-1:0]              hit_pos;
  logic [scba_pkg::ROW_AW-1:0] last_row;
  logic [2:0]                 fcls;
  logic                       ffound;
  logic [BW-1:0]              fpos;
  logic                       out_free;

  always_comb begin
    seg_cur   = '0;
    cnt_cur   = '0;
    first_cur = '0;
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      if (cls_r == 3'(c)) begin
        seg_cur   = seg_size_r[c];
        cnt_cur   = counts_r[8*c +: 8];
        first_cur = firsts_r[8*c +: 8];
      end
    end
    cls_base = scba_pkg::base_of(counts_r, cls_r);
    cls_end  = cls_base + BW'(cnt_cur);
    if (cls_end > scba_pkg::MAP_LIMIT) cls_end = scba_pkg::MAP_LIMIT;

    // free bits of the current row that fall inside the class range
    for (int i = 0; i < scba_pkg::ROW_W; i++) begin
      abs_pos      = {1'b0, row_r, scba_pkg::BIT_AW'(i)};
      free_mask[i] = !row_data[i] && (abs_pos >= base_r) && (abs_pos < end_r);
    end
    hit     = |free_mask;
    hit_idx = '0;
    for (int i = scba_pkg::ROW_W - 1; i >= 0; i--) begin
      if (free_mask[i]) hit_idx = scba_pkg::BIT_AW'(i);
    end
    hit_pos  = {1'b0, row_r, hit_idx};
    last_row = scba_pkg::ROW_AW'((end_r - BW'(1)) >> scba_pkg::BIT_AW);

    // highest class whose first bank is not above the freed bank
    fcls   = '0;
    ffound = 1'b0;
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      if (fbank_r >= firsts_r[8*c +: 8]) begin
        fcls   = 3'(c);
        ffound = 1'b1;
      end
    end
    fpos = base_r + BW'(quot[7:0]);
  end

  assign out_free = !ovalid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    type_nxt     = type_r;
    size_nxt     = size_r;
    fbank_nxt    = fbank_r;
    foff_nxt     = foff_r;
    cls_nxt      = cls_r;
    base_nxt     = base_r;
    end_nxt      = end_r;
    row_nxt      = row_r;
    bit_nxt      = bit_r;
    j_nxt        = j_r;
    prod_nxt     = prod_r;
    res_ok_nxt   = res_ok_r;
    res_bank_nxt = res_bank_r;
    res_off_nxt  = res_off_r;
    ovalid_nxt   = ovalid_r && out_stall;
    ook_nxt      = ook_r;
    obank_nxt    = obank_r;
    ooff_nxt     = ooff_r;
    map_req      = '0;
    div_req      = '0;
    in_stall     = !(state_r == scba_pkg::S_IDLE) || map_busy;

    case (state_r)
      scba_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          type_nxt     = in_req_type;
          size_nxt     = in_req_size;
          fbank_nxt    = in_free_bank;
          foff_nxt     = in_free_offset;
          cls_nxt      = '0;
          res_ok_nxt   = 1'b0;
          res_bank_nxt = '0;
          res_off_nxt  = '0;
          state_nxt    = in_req_type ? scba_pkg::S_FSEL : scba_pkg::S_CLASS;
        end
      end
      // try one class for an allocate
      scba_pkg::S_CLASS: begin
        if (cls_r == 3'(scba_pkg::NUM_CLASSES)) begin
          state_nxt = scba_pkg::S_FIN;
        end else if (seg_cur != '0 && size_r <= seg_cur && cls_base < cls_end) begin
          base_nxt  = cls_base;
          end_nxt   = cls_end;
          row_nxt   = cls_base[scba_pkg::POS_W-1:scba_pkg::BIT_AW];
          state_nxt = scba_pkg::S_RD;
        end else begin
          cls_nxt = cls_r + 3'd1;
        end
      end
      scba_pkg::S_RD: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = row_r;
        state_nxt       = scba_pkg::S_CHK;
      end
      scba_pkg::S_CHK: begin
        map_req.wr_addr = row_r;
        if (type_r) begin
          // free: clear the bit if it was set
          if (row_data[bit_r]) begin
            map_req.wr_en          = 1'b1;
            map_req.wr_data        = row_data;
            map_req.wr_data[bit_r] = 1'b0;
            res_ok_nxt             = 1'b1;
          end
          state_nxt = scba_pkg::S_FIN;
        end else if (hit) begin
          map_req.wr_en            = 1'b1;
          map_req.wr_data          = row_data;
          map_req.wr_data[hit_idx] = 1'b1;
          j_nxt                    = 8'(hit_pos - base_r);
          state_nxt                = scba_pkg::S_MUL;
        end else if (row_r == last_row) begin
          cls_nxt   = cls_r + 3'd1;
          state_nxt = scba_pkg::S_CLASS;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = scba_pkg::S_RD;
        end
      end
      scba_pkg::S_MUL: begin
        prod_nxt  = {14'd0, j_r} * {8'd0, seg_cur};
        state_nxt = scba_pkg::S_FORM;
      end
      scba_pkg::S_FORM: begin
        res_ok_nxt   = 1'b1;
        res_bank_nxt = 8'(first_cur + prod_r[21:scba_pkg::BANK_SH]);
        res_off_nxt  = prod_r[scba_pkg::BANK_SH-1:0];
        state_nxt    = scba_pkg::S_FIN;
      end
      // free: pick the class and start the segment index division
      scba_pkg::S_FSEL: begin
        cls_nxt  = fcls;
        base_nxt = scba_pkg::base_of(counts_r, fcls);
        if (!ffound || seg_size_r[fcls] == '0) begin
          state_nxt = scba_pkg::S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'(fbank_r - firsts_r[8*fcls +: 8]), foff_r};
          div_req.divisor  = seg_size_r[fcls];
          state_nxt        = scba_pkg::S_FDIV;
        end
      end
      scba_pkg::S_FDIV: begin
        if (div_done) state_nxt = scba_pkg::S_FIDX;
      end
      scba_pkg::S_FIDX: begin
        if (quot >= scba_pkg::DVD_W'(cnt_cur) || fpos >= scba_pkg::MAP_LIMIT) begin
          state_nxt = scba_pkg::S_FIN;
        end else begin
          row_nxt   = fpos[scba_pkg::POS_W-1:scba_pkg::BIT_AW];
          bit_nxt   = fpos[scba_pkg::BIT_AW-1:0];
          state_nxt = scba_pkg::S_RD;
        end
      end
      // hand the result to the output register
      scba_pkg::S_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ook_nxt    = res_ok_r;
          obank_nxt  = res_bank_r;
          ooff_nxt   = res_off_r;
          state_nxt  = scba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = scba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= scba_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    type_r     <= type_nxt;
    size_r     <= size_nxt;
    fbank_r    <= fbank_nxt;
    foff_r     <= foff_nxt;
    cls_r      <= cls_nxt;
    base_r     <= base_nxt;
    end_r      <= end_nxt;
    row_r      <= row_nxt;
    bit_r      <= bit_nxt;
    j_r        <= j_nxt;
    prod_r     <= prod_nxt;
    res_ok_r   <= res_ok_nxt;
    res_bank_r <= res_bank_nxt;
    res_off_r  <= res_off_nxt;
    ook_r      <= ook_nxt;
    obank_r    <= obank_nxt;
    ooff_r     <= ooff_nxt;
  end

  assign out_valid  = ovalid_r;
  assign out_ok     = ook_r;
  assign out_bank   = obank_r;
  assign out_offset = ooff_r;

  `SCBA_ASSERT_IMP(a_take_only_idle, !in_stall, state_r == scba_pkg::S_IDLE && !map_busy)
  `SCBA_ASSERT_IMP(a_write_in_check, map_req.wr_en, state_r == scba_pkg::S_CHK)
  `SCBA_ASSERT_IMP(a_div_done_waited, div_done, state_r == scba_pkg::S_FDIV)
  `SCBA_ASSERT_NXT(a_fin_loads_out, state_r == scba_pkg::S_FIN && out_free, ovalid_r)
endmodule
`default_nettype wire

@@ rtl/scba_div.sv @@
// iterative restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module scba_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire scba_pkg::div_req_t      req,
  output logic                         done,
  output logic [scba_pkg::DVD_W-1:0]   quot
);
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic [scba_pkg::SEG_W-1:0]   rem_r, rem_nxt;
  logic [scba_pkg::DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [scba_pkg::DVD_W-1:0]   q_r, q_nxt;
  logic [scba_pkg::SEG_W-1:0]   dvs_r, dvs_nxt;
  logic [scba_pkg::SEG_W:0]     rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, dvd_r[scba_pkg::DVD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[scba_pkg::DVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = scba_pkg::SEG_W'(rem_sh - {1'b0, dvs_r});
        q_nxt   = {q_r[scba_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[scba_pkg::SEG_W-1:0];
        q_nxt   = {q_r[scba_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(scba_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

@@ rtl/scba_map.sv @@
// used-bit map: row memory with a clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none
module scba_map (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire scba_pkg::map_req_t      req,
  output logic                         busy,
  output logic [scba_pkg::ROW_W-1:0]   rd_data
);
  logic [scba_pkg::ROW_W-1:0]  mem [scba_pkg::ROWS];
  logic                        clearing_r;
  logic [scba_pkg::ROW_AW-1:0] clr_cnt_r;
  logic [scba_pkg::ROW_W-1:0]  rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == scba_pkg::ROW_AW'(scba_pkg::ROWS - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) rd_data_r <= mem[req.rd_addr];
  end

  assign busy    = clearing_r;
  assign rd_data = rd_data_r;
endmodule
`default_nettype wire
